// File: rtl/hrs_pkg.sv
// Package for the HID release safety FSM: item/result types, phase, error and
// action codes, field widths. No dependencies.
`default_nettype none
package hrs_pkg;

    localparam int GEN_W    = 32;
    localparam int ATT_W    = 8;
    localparam int ACT_W    = 3;
    localparam int IN_DW    = 40;  // 35 payload bits padded to bytes
    localparam int OUT_DW   = 56;  // 50 payload bits padded to bytes

    localparam logic [GEN_W-1:0] GEN_NONE    = '0;
    localparam logic [GEN_W-1:0] GEN_FIRST   = GEN_W'(1);
    localparam logic [ATT_W-1:0] ATT_DEFAULT = ATT_W'(3);

    typedef enum logic [ACT_W-1:0] {
        ACT_CONNECT    = 3'd0,
        ACT_DISCONNECT = 3'd1,
        ACT_AUTH       = 3'd2,
        ACT_BEGIN      = 3'd3,
        ACT_COMPLETE   = 3'd4,
        ACT_RETRY      = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        PH_DISCONNECTED = 3'd0,
        PH_WAIT_AUTH    = 3'd1,
        PH_WAIT_PATH    = 3'd2,
        PH_RELEASING    = 3'd3,
        PH_CONFIRMED    = 3'd4,
        PH_FAILED       = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ER_OK            = 3'd0,
        ER_NOT_CONNECTED = 3'd1,
        ER_AUTH_PENDING  = 3'd2,
        ER_AUTH_FAILED   = 3'd3,
        ER_PATH_PENDING  = 3'd4,
        ER_KBD           = 3'd5,
        ER_CONSUMER      = 3'd6,
        ER_BOTH          = 3'd7
    } t_err;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             auth_success;
        logic [GEN_W-1:0] generation_in;
        logic             keyboard_ok;
        logic             consumer_ok;
    } t_item;

    typedef struct packed {
        logic             accepted;
        logic [GEN_W-1:0] generation_out;
        logic             is_connected;
        logic             is_authenticated;
        logic             is_ready;
        t_phase           phase;
        t_err             error_code;
        logic [ATT_W-1:0] attempts;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/hrs_core.sv
// Session state registers and per-event next-state logic.
// Depends on hrs_pkg.
`default_nettype none
module hrs_core (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_fire,      // registered item is processed
    input  hrs_pkg::t_item            i_item,
    input  wire [hrs_pkg::ATT_W-1:0]  i_max_att,
    output hrs_pkg::t_result          o_result
);
    import hrs_pkg::*;

    logic [GEN_W-1:0] r_gen, n_gen;
    logic             r_link, n_link;
    logic             r_auth, n_auth;
    logic [ATT_W-1:0] r_att, n_att;
    t_phase           r_phase, n_phase;
    t_err             r_err, n_err;
    logic             n_ok;

    logic [GEN_W-1:0] gen_bumped;
    logic             gen_ok;

    // generation skips zero on wrap
    assign gen_bumped = (r_gen == '1) ? GEN_FIRST : r_gen + GEN_FIRST;
    assign gen_ok     = (i_item.generation_in != GEN_NONE) &&
                        (i_item.generation_in == r_gen);

    // next state
    always_comb begin
        n_gen   = r_gen;
        n_link  = r_link;
        n_auth  = r_auth;
        n_att   = r_att;
        n_phase = r_phase;
        n_err   = r_err;
        n_ok    = 1'b0;
        unique case (i_item.action)
            ACT_CONNECT: begin
                n_gen   = gen_bumped;
                n_link  = 1'b1;
                n_auth  = 1'b0;
                n_att   = '0;
                n_phase = PH_WAIT_AUTH;
                n_err   = ER_AUTH_PENDING;
                n_ok    = 1'b1;
            end
            ACT_DISCONNECT: begin
                n_gen   = gen_bumped;
                n_link  = 1'b0;
                n_auth  = 1'b0;
                n_att   = '0;
                n_phase = PH_DISCONNECTED;
                n_err   = ER_NOT_CONNECTED;
                n_ok    = 1'b1;
            end
            ACT_AUTH: begin
                if (r_link) begin
                    n_auth  = i_item.auth_success;
                    n_att   = '0;
                    n_phase = i_item.auth_success ? PH_WAIT_PATH : PH_FAILED;
                    n_err   = i_item.auth_success ? ER_PATH_PENDING : ER_AUTH_FAILED;
                    n_ok    = 1'b1;
                end
            end
            ACT_BEGIN: begin
                if (r_link && r_auth && gen_ok && (r_att < i_max_att) &&
                    (r_phase == PH_WAIT_PATH || r_phase == PH_FAILED)) begin
                    n_att   = r_att + ATT_W'(1);
                    n_phase = PH_RELEASING;
                    n_ok    = 1'b1;
                end
            end
            ACT_COMPLETE: begin
                if (gen_ok && r_link && r_auth && r_phase == PH_RELEASING) begin
                    priority if (i_item.keyboard_ok && i_item.consumer_ok) begin
                        n_phase = PH_CONFIRMED;
                        n_err   = ER_OK;
                        n_ok    = 1'b1;
                    end else if (!i_item.keyboard_ok && !i_item.consumer_ok) begin
                        n_phase = PH_FAILED;
                        n_err   = ER_BOTH;
                    end else if (!i_item.keyboard_ok) begin
                        n_phase = PH_FAILED;
                        n_err   = ER_KBD;
                    end else begin
                        n_phase = PH_FAILED;
                        n_err   = ER_CONSUMER;
                    end
                end
            end
            ACT_RETRY: begin
                if (r_link && r_auth && r_phase != PH_RELEASING) begin
                    if (r_phase != PH_CONFIRMED) begin
                        n_att   = '0;
                        n_phase = PH_WAIT_PATH;
                        n_err   = ER_PATH_PENDING;
                    end
                    n_ok = 1'b1;
                end
            end
            default: ;  // unused codes: ignored
        endcase
    end

    // result snapshot
    always_comb begin
        o_result.accepted         = n_ok;
        o_result.generation_out   = n_gen;
        o_result.is_connected     = n_link;
        o_result.is_authenticated = n_auth;
        o_result.is_ready         = n_link && n_auth && (n_phase == PH_CONFIRMED);
        o_result.phase            = n_phase;
        o_result.error_code       = n_err;
        o_result.attempts         = n_att;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen   <= GEN_NONE;
            r_link  <= 1'b0;
            r_auth  <= 1'b0;
            r_att   <= '0;
            r_phase <= PH_DISCONNECTED;
            r_err   <= ER_NOT_CONNECTED;
        end else if (i_fire) begin
            r_gen   <= n_gen;
            r_link  <= n_link;
            r_auth  <= n_auth;
            r_att   <= n_att;
            r_phase <= n_phase;
            r_err   <= n_err;
        end
    end

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_gen) && $stable(r_att) && $stable(r_phase))
        else $error("state changed without an item");
    a_link_has_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link |-> r_gen != GEN_NONE)
        else $error("connected with zero generation");
    a_auth_needs_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_auth |-> r_link)
        else $error("authenticated while disconnected");
    a_releasing_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RELEASING |-> r_att != '0)
        else $error("releasing without an attempt counted");

endmodule
`default_nettype wire

// File: rtl/hrs_out_fifo.sv
// Two-entry result buffer decoupling the event logic from the output stream.
// Depends on hrs_pkg.
`default_nettype none
module hrs_out_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  hrs_pkg::t_result   i_data,
    output logic               o_full,
    output logic               o_valid,
    input  wire                i_ready,
    output hrs_pkg::t_result   o_data
);
    import hrs_pkg::*;

    t_result     r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop)
            n_count = r_count + 2'd1;
        else if (!i_push && pop)
            n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push)
                r_wr_ptr <= ~r_wr_ptr;
            if (pop)
                r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full result buffer");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

endmodule
`default_nettype wire

// File: rtl/hid_release_safety_fsm_top.sv
// Top level of the HID release safety FSM: input item register, config
// register, event core and result buffer. Depends on hrs_pkg, hrs_core, hrs_out_fifo.
// Path: an accepted item is held in the input item register, and its result is
//   registered into the result buffer, from which the master side takes it.
// Throughput: one item per cycle; the input register, the combinational event
//   logic and the two-entry result buffer keep the flow going while the master
//   side is ready. Input stalls only while both buffer entries are held.
// Reset: synchronous active-low i_rst_n; clears the session state
//   (not connected), empties all stages, max_release_attempts returns to 3.
`default_nettype none
module hid_release_safety_fsm_top (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // input items
    input  wire                        i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [0] auth_success, [32:1] generation_in, [33] keyboard_ok,
    // [34] consumer_ok, [39:35] zero
    input  wire [hrs_pkg::IN_DW-1:0]   i_s_axis_tdata,
    // [2:0] action
    input  wire [2:0]                  i_s_axis_tuser,
    // result items
    output logic                       o_m_axis_tvalid,
    input  wire                        i_m_axis_tready,
    // [0] accepted, [32:1] generation_out, [33] is_connected,
    // [34] is_authenticated, [35] is_ready, [38:36] phase,
    // [41:39] error_code, [49:42] attempts, [55:50] zero
    output logic [hrs_pkg::OUT_DW-1:0] o_m_axis_tdata,
    // max_release_attempts write
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [7:0]                  i_cfg_data
);
    import hrs_pkg::*;

    logic             r_in_vld;
    t_item            r_item;
    logic [ATT_W-1:0] r_max_att;

    logic     s_accept;
    logic     advance;
    logic     fifo_full;
    t_result  core_res;
    t_result  out_res;

    // the input register drains into the core whenever the buffer has room
    assign advance         = r_in_vld && !fifo_full;
    assign o_s_axis_tready = !r_in_vld || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_max_att <= ATT_DEFAULT;
        end else begin
            if (s_accept)
                r_in_vld <= 1'b1;
            else if (advance)
                r_in_vld <= 1'b0;
            if (i_cfg_valid)
                r_max_att <= i_cfg_data;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item.action        <= i_s_axis_tuser;
            r_item.auth_success  <= i_s_axis_tdata[0];
            r_item.generation_in <= i_s_axis_tdata[32:1];
            r_item.keyboard_ok   <= i_s_axis_tdata[33];
            r_item.consumer_ok   <= i_s_axis_tdata[34];
        end
    end

    hrs_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_item    (r_item),
        .i_max_att (r_max_att),
        .o_result  (core_res)
    );

    hrs_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (core_res),
        .o_full  (fifo_full),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_res)
    );

    assign o_m_axis_tdata = {6'b0,
                             out_res.attempts,
                             out_res.error_code,
                             out_res.phase,
                             out_res.is_ready,
                             out_res.is_authenticated,
                             out_res.is_connected,
                             out_res.generation_out,
                             out_res.accepted};

endmodule
`default_nettype wire
